FILE: design/llcp_pkg.sv
// Package for the line-line closest points block: widths, item types, status codes
// and pipeline depths shared by the front end, the arithmetic units, the top and the checker.
// Depends on nothing.
`default_nettype none

package llcp_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;
   localparam int OUT_BITS   = 40;
   localparam int STATUS_BITS = 3;

   // Differences of two coordinates, their products and the sums of three products.
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * COORD_BITS + 1;
   localparam int DOT_BITS  = 2 * COORD_BITS + 3;

   // Dividers work on magnitudes; the divisor is never negative.
   localparam int DIV_N = 6 * COORD_BITS + 8 + FRAC_BITS;
   localparam int DIV_M = 4 * COORD_BITS + 4;
   localparam int MUA_BITS = 4 * COORD_BITS + 6 + FRAC_BITS;
   localparam int MUB_BITS = DIV_N + 1;

   // Wide multiplier, cut into chunk products.
   localparam int MUL_A = MUB_BITS;
   localparam int MUL_B = DOT_BITS;
   localparam int MUL_P = MUL_A + MUL_B;
   localparam int MUL_A_CHUNK = 32;
   localparam int MUL_B_CHUNK = 24;
   localparam int MUL_NA = (MUL_A + MUL_A_CHUNK - 1) / MUL_A_CHUNK;
   localparam int MUL_NB = (MUL_B + MUL_B_CHUNK - 1) / MUL_B_CHUNK;
   localparam int MUL_A_PAD = MUL_NA * MUL_A_CHUNK;
   localparam int MUL_B_PAD = MUL_NB * MUL_B_CHUNK;
   localparam int MUL_PAD = MUL_A_PAD + MUL_B_PAD;
   localparam int PP_BITS = MUL_A_CHUNK + MUL_B_CHUNK + 2;

   localparam int SUM_BITS = MUL_P + 1;

   // Pipeline depths, counted in stages of the side-data line behind the front end.
   localparam int FRONT_LAT = 3;
   localparam int MUL_LAT   = 3;
   localparam int DIV_LAT   = DIV_N + 2;
   localparam int SIDE_DEN  = MUL_LAT + 1;
   localparam int SIDE_KA   = SIDE_DEN + DIV_LAT;
   localparam int SIDE_KB   = SIDE_KA + MUL_LAT + 1 + DIV_LAT;
   localparam int SIDE_LEN  = SIDE_KB + MUL_LAT + 1;
   localparam int RSP_LATENCY = FRONT_LAT + SIDE_LEN + 2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_LINE2_DEG = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_LINE1_DEG = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_PARALLEL  = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_SAT       = 3'd4;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [DOT_BITS-1:0]   dot_type;
   typedef logic signed [MUA_BITS-1:0]   mua_type;
   typedef logic signed [OUT_BITS-1:0]   out_type;

   typedef struct packed {
      coord_type p1_x;
      coord_type p1_y;
      coord_type p1_z;
      coord_type p2_x;
      coord_type p2_y;
      coord_type p2_z;
      coord_type p3_x;
      coord_type p3_y;
      coord_type p3_z;
      coord_type p4_x;
      coord_type p4_y;
      coord_type p4_z;
   } req_type;

   typedef struct packed {
      out_type pa_x;
      out_type pa_y;
      out_type pa_z;
      out_type pb_x;
      out_type pb_y;
      out_type pb_z;
      logic [STATUS_BITS-1:0] status;
   } rsp_type;

   // Everything an item carries alongside the arithmetic units.
   typedef struct packed {
      logic valid;
      coord_type [2:0] p1;
      coord_type [2:0] p3;
      diff_type [2:0] a;
      diff_type [2:0] b;
      dot_type d1343;
      dot_type d4321;
      dot_type d1321;
      dot_type d4343;
      dot_type d2121;
      logic a_zero;
      logic b_zero;
      logic par;
      mua_type mua;
   } side_type;

endpackage

`default_nettype wire

FILE: design/llcp_front.sv
// Front end: input register, direction vectors, elementwise products and dot products.
// Depends on llcp_pkg.
`default_nettype none

module llcp_front (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic accept,
   input  wire llcp_pkg::req_type req_item,
   output llcp_pkg::side_type side_out
);

   llcp_pkg::req_type in_ff;
   logic in_valid_ff;

   llcp_pkg::coord_type p1c [3];
   llcp_pkg::coord_type p2c [3];
   llcp_pkg::coord_type p3c [3];
   llcp_pkg::coord_type p4c [3];

   logic d_valid_ff;
   llcp_pkg::coord_type p1_ff [3];
   llcp_pkg::coord_type p3_ff [3];
   llcp_pkg::diff_type a_ff [3];
   llcp_pkg::diff_type b_ff [3];
   llcp_pkg::diff_type c_ff [3];

   logic m_valid_ff;
   llcp_pkg::coord_type p1m_ff [3];
   llcp_pkg::coord_type p3m_ff [3];
   llcp_pkg::diff_type am_ff [3];
   llcp_pkg::diff_type bm_ff [3];
   llcp_pkg::prod_type pr1343_ff [3];
   llcp_pkg::prod_type pr4321_ff [3];
   llcp_pkg::prod_type pr1321_ff [3];
   llcp_pkg::prod_type pr4343_ff [3];
   llcp_pkg::prod_type pr2121_ff [3];
   logic a_zero_ff;
   logic b_zero_ff;

   llcp_pkg::side_type side_in;
   llcp_pkg::side_type side_ff;

   always_comb begin
      p1c[0] = in_ff.p1_x; p1c[1] = in_ff.p1_y; p1c[2] = in_ff.p1_z;
      p2c[0] = in_ff.p2_x; p2c[1] = in_ff.p2_y; p2c[2] = in_ff.p2_z;
      p3c[0] = in_ff.p3_x; p3c[1] = in_ff.p3_y; p3c[2] = in_ff.p3_z;
      p4c[0] = in_ff.p4_x; p4c[1] = in_ff.p4_y; p4c[2] = in_ff.p4_z;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         m_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
         d_valid_ff <= in_valid_ff;
         m_valid_ff <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_ff <= req_item;
      end
      for (int i = 0; i < 3; i++) begin
         p1_ff[i] <= p1c[i];
         p3_ff[i] <= p3c[i];
         a_ff[i] <= llcp_pkg::diff_type'(p2c[i]) - llcp_pkg::diff_type'(p1c[i]);
         b_ff[i] <= llcp_pkg::diff_type'(p4c[i]) - llcp_pkg::diff_type'(p3c[i]);
         c_ff[i] <= llcp_pkg::diff_type'(p1c[i]) - llcp_pkg::diff_type'(p3c[i]);

         p1m_ff[i] <= p1_ff[i];
         p3m_ff[i] <= p3_ff[i];
         am_ff[i] <= a_ff[i];
         bm_ff[i] <= b_ff[i];
         pr1343_ff[i] <= c_ff[i] * b_ff[i];
         pr4321_ff[i] <= b_ff[i] * a_ff[i];
         pr1321_ff[i] <= c_ff[i] * a_ff[i];
         pr4343_ff[i] <= b_ff[i] * b_ff[i];
         pr2121_ff[i] <= a_ff[i] * a_ff[i];
      end
      a_zero_ff <= (a_ff[0] == '0) && (a_ff[1] == '0) && (a_ff[2] == '0);
      b_zero_ff <= (b_ff[0] == '0) && (b_ff[1] == '0) && (b_ff[2] == '0);
   end

   always_comb begin
      side_in.valid = m_valid_ff;
      for (int i = 0; i < 3; i++) begin
         side_in.p1[i] = p1m_ff[i];
         side_in.p3[i] = p3m_ff[i];
         side_in.a[i] = am_ff[i];
         side_in.b[i] = bm_ff[i];
      end
      side_in.d1343 = llcp_pkg::dot_type'(pr1343_ff[0]) + llcp_pkg::dot_type'(pr1343_ff[1])
                      + llcp_pkg::dot_type'(pr1343_ff[2]);
      side_in.d4321 = llcp_pkg::dot_type'(pr4321_ff[0]) + llcp_pkg::dot_type'(pr4321_ff[1])
                      + llcp_pkg::dot_type'(pr4321_ff[2]);
      side_in.d1321 = llcp_pkg::dot_type'(pr1321_ff[0]) + llcp_pkg::dot_type'(pr1321_ff[1])
                      + llcp_pkg::dot_type'(pr1321_ff[2]);
      side_in.d4343 = llcp_pkg::dot_type'(pr4343_ff[0]) + llcp_pkg::dot_type'(pr4343_ff[1])
                      + llcp_pkg::dot_type'(pr4343_ff[2]);
      side_in.d2121 = llcp_pkg::dot_type'(pr2121_ff[0]) + llcp_pkg::dot_type'(pr2121_ff[1])
                      + llcp_pkg::dot_type'(pr2121_ff[2]);
      side_in.a_zero = a_zero_ff;
      side_in.b_zero = b_zero_ff;
      side_in.par = 1'b0;
      side_in.mua = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff.valid <= 1'b0;
      end else begin
         side_ff <= side_in;
      end
   end

   assign side_out = side_ff;

endmodule

`default_nettype wire

FILE: design/llcp_mul.sv
// Pipelined wide signed multiplier: chunk products, column sums, final sum (three stages).
// Depends on llcp_pkg.
`default_nettype none

module llcp_mul (
   input  wire logic clock,
   input  wire logic signed [llcp_pkg::MUL_A-1:0] a_in,
   input  wire logic signed [llcp_pkg::MUL_B-1:0] b_in,
   output logic signed [llcp_pkg::MUL_P-1:0] p_out
);

   logic signed [llcp_pkg::MUL_A_PAD-1:0] a_pad;
   logic signed [llcp_pkg::MUL_B_PAD-1:0] b_pad;
   logic signed [llcp_pkg::MUL_A_CHUNK:0] op_a [llcp_pkg::MUL_NA];
   logic signed [llcp_pkg::MUL_B_CHUNK:0] op_b [llcp_pkg::MUL_NB];
   logic signed [llcp_pkg::PP_BITS-1:0] pp_ff [llcp_pkg::MUL_NA][llcp_pkg::MUL_NB];
   logic signed [llcp_pkg::MUL_PAD-1:0] col_in [llcp_pkg::MUL_NB];
   logic signed [llcp_pkg::MUL_PAD-1:0] col_ff [llcp_pkg::MUL_NB];
   logic signed [llcp_pkg::MUL_PAD-1:0] p_in;
   logic signed [llcp_pkg::MUL_PAD-1:0] p_ff;

   assign a_pad = llcp_pkg::MUL_A_PAD'(a_in);
   assign b_pad = llcp_pkg::MUL_B_PAD'(b_in);

   // Only the top chunk of each operand carries the sign.
   always_comb begin
      for (int i = 0; i < llcp_pkg::MUL_NA; i++) begin
         op_a[i] = {(i == llcp_pkg::MUL_NA - 1) ?
                    a_pad[(i + 1) * llcp_pkg::MUL_A_CHUNK - 1] : 1'b0,
                    a_pad[i * llcp_pkg::MUL_A_CHUNK +: llcp_pkg::MUL_A_CHUNK]};
      end
      for (int j = 0; j < llcp_pkg::MUL_NB; j++) begin
         op_b[j] = {(j == llcp_pkg::MUL_NB - 1) ?
                    b_pad[(j + 1) * llcp_pkg::MUL_B_CHUNK - 1] : 1'b0,
                    b_pad[j * llcp_pkg::MUL_B_CHUNK +: llcp_pkg::MUL_B_CHUNK]};
      end
   end

   always_comb begin
      for (int j = 0; j < llcp_pkg::MUL_NB; j++) begin
         col_in[j] = '0;
         for (int i = 0; i < llcp_pkg::MUL_NA; i++) begin
            col_in[j] = col_in[j] +
                        (llcp_pkg::MUL_PAD'(pp_ff[i][j]) <<< (llcp_pkg::MUL_A_CHUNK * i));
         end
      end
      p_in = '0;
      for (int j = 0; j < llcp_pkg::MUL_NB; j++) begin
         p_in = p_in + (col_ff[j] <<< (llcp_pkg::MUL_B_CHUNK * j));
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < llcp_pkg::MUL_NA; i++) begin
         for (int j = 0; j < llcp_pkg::MUL_NB; j++) begin
            pp_ff[i][j] <= op_a[i] * op_b[j];
         end
      end
      for (int j = 0; j < llcp_pkg::MUL_NB; j++) begin
         col_ff[j] <= col_in[j];
      end
      p_ff <= p_in;
   end

   assign p_out = p_ff[llcp_pkg::MUL_P-1:0];

endmodule

`default_nettype wire

FILE: design/llcp_div.sv
// Pipelined restoring divider, one quotient bit per stage, truncating toward zero.
// The divisor is taken as non-negative. Depends on llcp_pkg.
`default_nettype none

module llcp_div (
   input  wire logic clock,
   input  wire logic signed [llcp_pkg::DIV_N:0] num_in,
   input  wire logic [llcp_pkg::DIV_M-1:0] den_in,
   output logic signed [llcp_pkg::DIV_N:0] quo_out
);

   localparam int N = llcp_pkg::DIV_N;
   localparam int M = llcp_pkg::DIV_M;

   logic [N:0] mag_in;
   logic [N-1:0] num_ff [0:N-1];
   logic [M-1:0] rem_ff [0:N-1];
   logic [M-1:0] den_ff [0:N-1];
   logic [N-1:0] quo_ff [0:N];
   logic neg_ff [0:N];
   logic [M:0] trial [0:N-1];
   logic fit [0:N-1];
   logic signed [N:0] quo_ff_out;

   assign mag_in = num_in[N] ? -num_in : num_in;

   always_comb begin
      for (int s = 0; s < N; s++) begin
         trial[s] = {rem_ff[s], num_ff[s][N-1]};
         fit[s] = trial[s] >= {1'b0, den_ff[s]};
      end
   end

   always_ff @(posedge clock) begin
      num_ff[0] <= mag_in[N-1:0];
      rem_ff[0] <= '0;
      den_ff[0] <= den_in;
      quo_ff[0] <= '0;
      neg_ff[0] <= num_in[N];
      for (int s = 0; s < N; s++) begin
         if (s < N - 1) begin
            num_ff[s+1] <= num_ff[s] << 1;
            den_ff[s+1] <= den_ff[s];
            if (fit[s]) begin
               rem_ff[s+1] <= M'(trial[s] - {1'b0, den_ff[s]});
            end else begin
               rem_ff[s+1] <= trial[s][M-1:0];
            end
         end
         quo_ff[s+1] <= {quo_ff[s][N-2:0], fit[s]};
         neg_ff[s+1] <= neg_ff[s];
      end
      if (neg_ff[N]) begin
         quo_ff_out <= -$signed({1'b0, quo_ff[N]});
      end else begin
         quo_ff_out <= $signed({1'b0, quo_ff[N]});
      end
   end

   assign quo_out = quo_ff_out;

endmodule

`default_nettype wire

FILE: design/line_line_closest_points.sv
// Top level of the line-line closest points block: front end, wide multipliers,
// two pipelined dividers, final sums and saturation. Depends on llcp_pkg, llcp_front, llcp_mul and llcp_div.
//
// One item enters per clock: busy is high only during reset and in the first cycle after it,
// so start may be held high continuously. Each item yields exactly one result on rsp_item,
// marked by a one-cycle rsp_valid strobe, in input order. The result path runs through the
// two restoring dividers in series, each one quotient bit per stage (DIV_N+2 stages), plus
// three stage multipliers around them. There is no back-pressure: the receiver must take
// every result in the cycle its strobe is high.
`default_nettype none

module line_line_closest_points (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic start,
   input  wire llcp_pkg::req_type req_item,
   output logic busy,
   output logic rsp_valid,
   output llcp_pkg::rsp_type rsp_item
);

   localparam int KA = llcp_pkg::SIDE_KA;
   localparam int KB = llcp_pkg::SIDE_KB;
   localparam int SL = llcp_pkg::SIDE_LEN;
   localparam int SW = llcp_pkg::SUM_BITS;
   localparam int OB = llcp_pkg::OUT_BITS;
   localparam logic signed [SW-1:0] SAT_HI = {{(SW - OB + 1){1'b0}}, {(OB - 1){1'b1}}};
   localparam logic signed [SW-1:0] SAT_LO = {{(SW - OB + 1){1'b1}}, {(OB - 1){1'b0}}};

   function automatic logic [OB:0] saturate(input logic signed [SW-1:0] v);
      logic [OB:0] r;
      if (v > SAT_HI) begin
         r = {1'b1, SAT_HI[OB-1:0]};
      end else if (v < SAT_LO) begin
         r = {1'b1, SAT_LO[OB-1:0]};
      end else begin
         r = {1'b0, v[OB-1:0]};
      end
      return r;
   endfunction

   logic busy_ff;
   logic accept;
   llcp_pkg::side_type side_out;
   llcp_pkg::side_type side_in [1:SL];
   llcp_pkg::side_type side_ff [1:SL];

   logic signed [llcp_pkg::MUL_P-1:0] p_dd, p_bb, p_n1, p_n2, p_mb;
   logic signed [llcp_pkg::MUL_P-1:0] p_pa [3];
   logic signed [llcp_pkg::MUL_P-1:0] p_pb [3];
   logic signed [llcp_pkg::MUL_P-1:0] denom, numer;
   logic [llcp_pkg::DIV_M-1:0] den_ff;
   logic signed [llcp_pkg::DIV_N:0] numa_ff;
   logic signed [llcp_pkg::DIV_N:0] numb_in, numb_ff;
   logic signed [llcp_pkg::DIV_N:0] quo_a, quo_b;
   logic signed [SW-1:0] sum_ff [6];
   logic [OB:0] sat [6];
   logic clamped;

   llcp_pkg::rsp_type rsp_in, rsp_ff;
   logic rsp_valid_ff;

   assign accept = start && !busy_ff;
   assign busy = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
      end
   end

   llcp_front u_front (
      .clock(clock), .reset(reset), .accept(accept), .req_item(req_item), .side_out(side_out)
   );

   llcp_mul u_mul_dd (.clock(clock), .a_in(llcp_pkg::MUL_A'(side_out.d2121)),
                      .b_in(llcp_pkg::MUL_B'(side_out.d4343)), .p_out(p_dd));
   llcp_mul u_mul_bb (.clock(clock), .a_in(llcp_pkg::MUL_A'(side_out.d4321)),
                      .b_in(llcp_pkg::MUL_B'(side_out.d4321)), .p_out(p_bb));
   llcp_mul u_mul_n1 (.clock(clock), .a_in(llcp_pkg::MUL_A'(side_out.d1343)),
                      .b_in(llcp_pkg::MUL_B'(side_out.d4321)), .p_out(p_n1));
   llcp_mul u_mul_n2 (.clock(clock), .a_in(llcp_pkg::MUL_A'(side_out.d1321)),
                      .b_in(llcp_pkg::MUL_B'(side_out.d4343)), .p_out(p_n2));

   assign denom = p_dd - p_bb;
   assign numer = p_n1 - p_n2;

   always_ff @(posedge clock) begin
      den_ff <= denom[llcp_pkg::DIV_M-1:0];
      numa_ff <= llcp_pkg::MUB_BITS'(numer) <<< llcp_pkg::FRAC_BITS;
   end

   llcp_div u_div_a (.clock(clock), .num_in(numa_ff), .den_in(den_ff), .quo_out(quo_a));

   llcp_mul u_mul_mb (.clock(clock), .a_in(quo_a),
                      .b_in(llcp_pkg::MUL_B'(side_ff[KA].d4321)), .p_out(p_mb));

   assign numb_in = (llcp_pkg::MUB_BITS'(side_ff[KA + llcp_pkg::MUL_LAT].d1343)
                     <<< llcp_pkg::FRAC_BITS) + p_mb[llcp_pkg::MUB_BITS-1:0];

   always_ff @(posedge clock) begin
      numb_ff <= numb_in;
   end

   llcp_div u_div_b (.clock(clock), .num_in(numb_ff),
                     .den_in(llcp_pkg::DIV_M'(side_ff[KA + llcp_pkg::MUL_LAT + 1].d4343)),
                     .quo_out(quo_b));

   for (genvar i = 0; i < 3; i++) begin : g_coord
      llcp_mul u_mul_pa (.clock(clock), .a_in(llcp_pkg::MUL_A'(side_ff[KB].mua)),
                         .b_in(llcp_pkg::MUL_B'(side_ff[KB].a[i])), .p_out(p_pa[i]));
      llcp_mul u_mul_pb (.clock(clock), .a_in(quo_b),
                         .b_in(llcp_pkg::MUL_B'(side_ff[KB].b[i])), .p_out(p_pb[i]));
   end

   // Side data follows each item; the parallel flag and mua are filled in on the way.
   always_comb begin
      side_in[1] = side_out;
      for (int k = 2; k <= SL; k++) begin
         side_in[k] = side_ff[k-1];
      end
      side_in[llcp_pkg::SIDE_DEN].par = (denom == '0);
      side_in[KA + 1].mua = quo_a[llcp_pkg::MUA_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 1; k <= SL; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else begin
         for (int k = 1; k <= SL; k++) begin
            side_ff[k] <= side_in[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         sum_ff[i] <= (SW'(side_ff[KB + llcp_pkg::MUL_LAT].p1[i]) <<< llcp_pkg::FRAC_BITS)
                      + SW'(p_pa[i]);
         sum_ff[3 + i] <= (SW'(side_ff[KB + llcp_pkg::MUL_LAT].p3[i]) <<< llcp_pkg::FRAC_BITS)
                          + SW'(p_pb[i]);
      end
   end

   always_comb begin
      clamped = 1'b0;
      for (int i = 0; i < 6; i++) begin
         sat[i] = saturate(sum_ff[i]);
         clamped = clamped | sat[i][OB];
      end
      rsp_in.pa_x = sat[0][OB-1:0];
      rsp_in.pa_y = sat[1][OB-1:0];
      rsp_in.pa_z = sat[2][OB-1:0];
      rsp_in.pb_x = sat[3][OB-1:0];
      rsp_in.pb_y = sat[4][OB-1:0];
      rsp_in.pb_z = sat[5][OB-1:0];
      rsp_in.status = llcp_pkg::STATUS_OK;
      priority if (side_ff[SL].b_zero) begin
         rsp_in = '0;
         rsp_in.status = llcp_pkg::STATUS_LINE2_DEG;
      end else if (side_ff[SL].a_zero) begin
         rsp_in = '0;
         rsp_in.status = llcp_pkg::STATUS_LINE1_DEG;
      end else if (side_ff[SL].par) begin
         rsp_in = '0;
         rsp_in.status = llcp_pkg::STATUS_PARALLEL;
      end else if (clamped) begin
         rsp_in.status = llcp_pkg::STATUS_SAT;
      end else begin
         rsp_in.status = llcp_pkg::STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= side_ff[SL].valid;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item = rsp_ff;

endmodule

`default_nettype wire

FILE: design/llcp_checker.sv
// Port-level checker for line_line_closest_points, attached with a bind statement.
// Depends on llcp_pkg.
`default_nettype none

module llcp_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic start,
   input wire logic busy,
   input wire logic rsp_valid,
   input wire llcp_pkg::rsp_type rsp_item
);

   localparam logic signed [llcp_pkg::OUT_BITS-1:0] OUT_HI = {1'b0, {(llcp_pkg::OUT_BITS-1){1'b1}}};
   localparam logic signed [llcp_pkg::OUT_BITS-1:0] OUT_LO = {1'b1, {(llcp_pkg::OUT_BITS-1){1'b0}}};

   // Every accepted item comes out after the fixed latency, and nothing else does.
   a_item_out: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##(llcp_pkg::RSP_LATENCY) rsp_valid)
      else $error("accepted item produced no result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, llcp_pkg::RSP_LATENCY))
      else $error("result without an accepted item");

   // Degenerate and parallel cases carry all-zero points.
   a_zero_points: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_item.status == llcp_pkg::STATUS_LINE2_DEG ||
                    rsp_item.status == llcp_pkg::STATUS_LINE1_DEG ||
                    rsp_item.status == llcp_pkg::STATUS_PARALLEL)
      |-> rsp_item.pa_x == '0 && rsp_item.pa_y == '0 && rsp_item.pa_z == '0 &&
          rsp_item.pb_x == '0 && rsp_item.pb_y == '0 && rsp_item.pb_z == '0)
      else $error("degenerate result with nonzero points");

   // A saturated result has at least one coordinate pinned to a range limit.
   a_sat_pinned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == llcp_pkg::STATUS_SAT
      |-> rsp_item.pa_x == OUT_HI || rsp_item.pa_x == OUT_LO ||
          rsp_item.pa_y == OUT_HI || rsp_item.pa_y == OUT_LO ||
          rsp_item.pa_z == OUT_HI || rsp_item.pa_z == OUT_LO ||
          rsp_item.pb_x == OUT_HI || rsp_item.pb_x == OUT_LO ||
          rsp_item.pb_y == OUT_HI || rsp_item.pb_y == OUT_LO ||
          rsp_item.pb_z == OUT_HI || rsp_item.pb_z == OUT_LO)
      else $error("saturated status with no clamped coordinate");

endmodule

bind line_line_closest_points llcp_checker u_llcp_checker (.*);

`default_nettype wire
